FILE: src/prefix_compressed_block_encoder_macros.svh
// Assertion macros shared by the prefix-compressed block encoder RTL.
`ifndef PREFIX_COMPRESSED_BLOCK_ENCODER_MACROS_SVH
`define PREFIX_COMPRESSED_BLOCK_ENCODER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PCBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcbe assertion failed");

// Next-cycle implication, checked while out of reset.
`define PCBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcbe assertion failed");

`endif

FILE: src/pcbe_pkg.sv
// Types, codes and helper functions of the prefix-compressed block encoder.
`default_nettype none
package pcbe_pkg;

	// Input operation codes.
	localparam logic [1:0] OP_BEGIN  = 2'd0;
	localparam logic [1:0] OP_KEY    = 2'd1;
	localparam logic [1:0] OP_VALUE  = 2'd2;
	localparam logic [1:0] OP_FINISH = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_OFFSET = 2'd1;
	localparam logic [1:0] KIND_COUNT  = 2'd2;

	// Command types between the front and the back.
	localparam logic [1:0] CMD_HDR  = 2'd0;
	localparam logic [1:0] CMD_BYTE = 2'd1;
	localparam logic [1:0] CMD_WORD = 2'd2;

	// Register map.
	localparam int         APB_AW               = 3;
	localparam logic [0:0] REG_RESTART_INTERVAL = 1'b0;
	localparam int         INTERVAL_W           = 11;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 11'd16;

	// Length fields in commands, wide enough for the largest key store.
	localparam int LEN_W  = 13;
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data_byte;
		logic [8:0]  key_length;
		logic [31:0] val_len;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_value;
		logic        overflow;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0]       ctype;
		logic [LEN_W-1:0] shared;
		logic [LEN_W-1:0] unshared;
		logic [31:0]      vlen;
		logic [31:0]      value;
		logic [1:0]       wkind;
		logic             has_byte;
		logic             ovf;
		logic             last;
	} cmd_t;

	// Number of bytes in the LEB128 encoding of a 32-bit value.
	function automatic logic [2:0] varint_len(input logic [31:0] v);
		logic [2:0] n;
		n = 3'd1;
		if (|v[31:7])  n = 3'd2;
		if (|v[31:14]) n = 3'd3;
		if (|v[31:21]) n = 3'd4;
		if (|v[31:28]) n = 3'd5;
		return n;
	endfunction

endpackage
`default_nettype wire

FILE: src/pcbe_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
`default_nettype none
interface pcbe_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: src/pcbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: src/pcbe_queue.sv
// Short command queue between the front and the back.
`default_nettype none
`include "prefix_compressed_block_encoder_macros.svh"
module pcbe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pcbe_pkg::cmd_t wdata,
	input  logic           pop,
	output pcbe_pkg::cmd_t rdata,
	output logic           full,
	output logic           empty
);
	import pcbe_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PCBE_ASSERT_IMP(a_no_overrun, clk, arst_n, push, !full)
	`PCBE_ASSERT_IMP(a_no_underrun, clk, arst_n, pop, !empty)
endmodule
`default_nettype wire

FILE: src/pcbe_front.sv
// Front part: takes input items, tracks key matching and restarts, issues commands.
`default_nettype none
`include "prefix_compressed_block_encoder_macros.svh"
module pcbe_front #(
	parameter int MAX_KEY_BYTES = 256,
	parameter int MAX_RESTARTS  = 63
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pcbe_stream_if.sink                      item,
	input  logic [pcbe_pkg::INTERVAL_W-1:0]  restart_interval,
	input  logic                             q_full,
	output logic                             q_push,
	output pcbe_pkg::cmd_t                   q_data
);
	import pcbe_pkg::*;

	localparam int KAW = $clog2(MAX_KEY_BYTES);
	localparam int KPW = $clog2(MAX_KEY_BYTES + 1);
	localparam int RCW = $clog2(MAX_RESTARTS + 1);
	localparam int RAW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;
	localparam logic [KPW-1:0] MAXK = KPW'(MAX_KEY_BYTES);
	localparam logic [RCW-1:0] MAXR = RCW'(MAX_RESTARTS);

	logic [KPW-1:0]        prev_key_len_q, cur_key_len_q, key_pos_q, key_pos_d, key_pos_inc;
	logic [KPW-1:0]        klen_sat, hdr_shared, hdr_total, hdr_unshared;
	logic [31:0]           cur_value_len_q, byte_offset_q, hdr_vlen, rst_rdata;
	logic                  still_matching_q, header_sent_q, overflow_q;
	logic [INTERVAL_W-1:0] esr_q, interval_eff;
	logic [RCW-1:0]        restart_count_q, n_q, idx_q, idx_d;
	logic                  sweep_q, sweep_ovf_q;
	logic [7:0]            key_rdata;
	logic                  accept, restart, key_in_range, match, key_last;
	logic                  push_hdr, push_byte, hdr_has_byte, key_we, rst_we, begin_ovf;
	logic [4:0]            offset_inc;

	assign item.ready = !sweep_q && !q_full;
	assign accept     = item.valid && item.ready;

	// Classification of the incoming item against the current entry.
	assign interval_eff = (restart_interval == '0) ? INTERVAL_W'(1) : restart_interval;
	assign restart      = (esr_q >= interval_eff);
	assign key_in_range = (key_pos_q < cur_key_len_q);
	assign key_pos_inc  = key_pos_q + 1'b1;
	assign key_last     = (key_pos_inc == cur_key_len_q);
	assign match        = still_matching_q && (key_pos_q < prev_key_len_q) &&
	                      (key_rdata == item.payload.data_byte);
	assign klen_sat     = (32'(item.payload.key_length) > 32'(MAX_KEY_BYTES)) ? MAXK :
	                      KPW'(item.payload.key_length);
	assign begin_ovf    = accept && !sweep_q && (item.payload.op == OP_BEGIN) && restart &&
	                      (restart_count_q >= MAXR);
	assign hdr_unshared = hdr_total - hdr_shared;

	// Decide what the item produces and where the stores are accessed.
	always_comb begin
		push_hdr     = 1'b0;
		push_byte    = 1'b0;
		hdr_shared   = '0;
		hdr_total    = '0;
		hdr_vlen     = '0;
		hdr_has_byte = 1'b0;
		key_we       = 1'b0;
		rst_we       = 1'b0;
		key_pos_d    = key_pos_q;
		idx_d        = idx_q;
		if (sweep_q) begin
			if (!q_full) begin
				idx_d = idx_q + 1'b1;
			end
		end else if (accept) begin
			unique case (item.payload.op)
				OP_BEGIN: begin
					key_pos_d = '0;
					rst_we    = restart && (restart_count_q < MAXR);
					if (klen_sat == '0) begin
						push_hdr = 1'b1;
						hdr_vlen = item.payload.val_len;
					end
				end
				OP_KEY: begin
					if (key_in_range) begin
						key_we    = 1'b1;
						key_pos_d = key_pos_inc;
						hdr_total = cur_key_len_q;
						hdr_vlen  = cur_value_len_q;
						if (!header_sent_q && !match) begin
							push_hdr     = 1'b1;
							hdr_shared   = key_pos_q;
							hdr_has_byte = 1'b1;
						end else if (header_sent_q) begin
							push_byte = 1'b1;
						end else if (key_last) begin
							push_hdr   = 1'b1;
							hdr_shared = cur_key_len_q;
						end
					end
				end
				OP_VALUE: begin
					push_byte = header_sent_q && (key_pos_q == cur_key_len_q) &&
					            (cur_value_len_q != '0);
				end
				OP_FINISH: begin
					key_pos_d = '0;
					idx_d     = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Command to the back, and the block bytes it will emit.
	always_comb begin
		q_data     = '0;
		q_push     = 1'b0;
		offset_inc = '0;
		if (sweep_q) begin
			q_push       = !q_full;
			q_data.ctype = CMD_WORD;
			q_data.ovf   = sweep_ovf_q;
			if (idx_q == n_q) begin
				q_data.wkind = KIND_COUNT;
				q_data.value = 32'(n_q);
				q_data.last  = 1'b1;
			end else begin
				q_data.wkind = KIND_OFFSET;
				q_data.value = (idx_q == '0) ? '0 : rst_rdata;
			end
		end else if (push_hdr) begin
			q_push          = 1'b1;
			q_data.ctype    = CMD_HDR;
			q_data.shared   = LEN_W'(hdr_shared);
			q_data.unshared = LEN_W'(hdr_unshared);
			q_data.vlen     = hdr_vlen;
			q_data.value    = 32'(item.payload.data_byte);
			q_data.wkind    = KIND_BYTE;
			q_data.has_byte = hdr_has_byte;
			q_data.ovf      = overflow_q | begin_ovf;
			q_data.last     = 1'b1;
			offset_inc      = 5'(varint_len(32'(hdr_shared))) +
			                  5'(varint_len(32'(hdr_unshared))) +
			                  5'(varint_len(hdr_vlen)) + 5'(hdr_has_byte);
		end else if (push_byte) begin
			q_push       = 1'b1;
			q_data.ctype = CMD_BYTE;
			q_data.value = 32'(item.payload.data_byte);
			q_data.wkind = KIND_BYTE;
			q_data.ovf   = overflow_q;
			q_data.last  = 1'b1;
			offset_inc   = 5'd1;
		end
	end

	// Entry and block state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key_len_q   <= '0;
			cur_key_len_q    <= '0;
			cur_value_len_q  <= '0;
			key_pos_q        <= '0;
			still_matching_q <= 1'b0;
			header_sent_q    <= 1'b0;
			esr_q            <= '0;
			byte_offset_q    <= '0;
			restart_count_q  <= RCW'(1);
			overflow_q       <= 1'b0;
			sweep_q          <= 1'b0;
			sweep_ovf_q      <= 1'b0;
			idx_q            <= '0;
			n_q              <= '0;
		end else begin
			// Finish restarts the block offset; otherwise it grows by the bytes issued.
			if (accept && (item.payload.op == OP_FINISH)) begin
				byte_offset_q <= '0;
			end else begin
				byte_offset_q <= byte_offset_q + 32'(offset_inc);
			end
			if (sweep_q && !q_full) begin
				idx_q <= idx_d;
				if (idx_q == n_q) begin
					sweep_q <= 1'b0;
				end
			end
			if (accept) begin
				unique case (item.payload.op)
					OP_BEGIN: begin
						if (restart) begin
							if (restart_count_q < MAXR) begin
								restart_count_q <= restart_count_q + 1'b1;
							end else begin
								overflow_q <= 1'b1;
							end
							esr_q <= INTERVAL_W'(1);
						end else begin
							esr_q <= esr_q + 1'b1;
						end
						prev_key_len_q   <= key_pos_q;
						key_pos_q        <= '0;
						cur_key_len_q    <= klen_sat;
						cur_value_len_q  <= item.payload.val_len;
						still_matching_q <= !restart && (klen_sat != '0);
						header_sent_q    <= (klen_sat == '0);
					end
					OP_KEY: begin
						key_pos_q <= key_pos_d;
						if (push_hdr) begin
							header_sent_q    <= 1'b1;
							still_matching_q <= 1'b0;
						end
					end
					OP_VALUE: begin
						if (push_byte) begin
							cur_value_len_q <= cur_value_len_q - 1'b1;
						end
					end
					OP_FINISH: begin
						prev_key_len_q   <= '0;
						cur_key_len_q    <= '0;
						cur_value_len_q  <= '0;
						key_pos_q        <= '0;
						still_matching_q <= 1'b0;
						header_sent_q    <= 1'b0;
						esr_q            <= '0;
						restart_count_q  <= RCW'(1);
						overflow_q       <= 1'b0;
						sweep_q          <= 1'b1;
						sweep_ovf_q      <= overflow_q;
						idx_q            <= '0;
						n_q              <= restart_count_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Previous key bytes, read one position ahead of the next key byte.
	pcbe_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_key_store (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_pos_q[KAW-1:0]),
		.wdata (item.payload.data_byte),
		.raddr (key_pos_d[KAW-1:0]),
		.rdata (key_rdata)
	);

	// Restart offsets; entry zero is never written, and index zero is sent as offset zero instead.
	pcbe_ram #(.WIDTH(32), .DEPTH(MAX_RESTARTS)) u_restart_store (
		.clk   (clk),
		.we    (rst_we),
		.waddr (restart_count_q[RAW-1:0]),
		.wdata (byte_offset_q),
		.raddr (idx_d[RAW-1:0]),
		.rdata (rst_rdata)
	);

	`PCBE_ASSERT_IMP(a_key_pos_bound, clk, arst_n, 1'b1, key_pos_q <= cur_key_len_q)
	`PCBE_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, (restart_count_q != '0) && (restart_count_q <= MAXR))
	`PCBE_ASSERT_NXT(a_finish_clears, clk, arst_n, accept && (item.payload.op == OP_FINISH), sweep_q && (byte_offset_q == '0))
endmodule
`default_nettype wire

FILE: src/pcbe_back.sv
// Back part: expands commands into varint header bytes, data bytes and words.
`default_nettype none
`include "prefix_compressed_block_encoder_macros.svh"
module pcbe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  pcbe_pkg::cmd_t q_data,
	output logic           q_pop,
	pcbe_stream_if.source  result
);
	import pcbe_pkg::*;

	localparam logic [2:0] PH_SH   = 3'd0;
	localparam logic [2:0] PH_UN   = 3'd1;
	localparam logic [2:0] PH_VL   = 3'd2;
	localparam logic [2:0] PH_BYTE = 3'd3;
	localparam logic [2:0] PH_WORD = 3'd4;

	logic        busy_q, out_valid_q;
	logic [2:0]  phase_q;
	cmd_t        cmd_q;
	logic [31:0] v_q;
	result_t     out_q, res;
	logic        emit, done, var_more;

	assign emit     = busy_q && (!out_valid_q || result.ready);
	assign var_more = |v_q[31:7];
	assign q_pop    = !q_empty && (!busy_q || (emit && done));

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	// Next result of the current command.
	always_comb begin
		res.kind      = KIND_BYTE;
		res.out_value = '0;
		res.overflow  = cmd_q.ovf;
		done          = 1'b0;
		unique case (phase_q)
			PH_SH, PH_UN, PH_VL: begin
				res.out_value = {24'd0, var_more, v_q[6:0]};
				done          = !var_more && (phase_q == PH_VL) && !cmd_q.has_byte;
			end
			PH_BYTE: begin
				res.out_value = {24'd0, cmd_q.value[7:0]};
				done          = 1'b1;
			end
			PH_WORD: begin
				res.kind      = cmd_q.wkind;
				res.out_value = cmd_q.value;
				done          = 1'b1;
			end
			default: begin
				done = 1'b1;
			end
		endcase
		res.last = done && cmd_q.last;
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Command sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_SH;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			unique case (q_data.ctype)
				CMD_HDR:  phase_q <= PH_SH;
				CMD_BYTE: phase_q <= PH_BYTE;
				default:  phase_q <= PH_WORD;
			endcase
		end else if (emit) begin
			if (done) begin
				busy_q <= 1'b0;
			end else if (!var_more) begin
				unique case (phase_q)
					PH_SH:   phase_q <= PH_UN;
					PH_UN:   phase_q <= PH_VL;
					default: phase_q <= PH_BYTE;
				endcase
			end
		end
	end

	// Command payload and varint shifter.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
			v_q   <= 32'(q_data.shared);
		end else if (emit && !done) begin
			if (var_more) begin
				v_q <= v_q >> 7;
			end else if (phase_q == PH_SH) begin
				v_q <= 32'(cmd_q.unshared);
			end else begin
				v_q <= cmd_q.vlen;
			end
		end
	end

	`PCBE_ASSERT_NXT(a_pick_up, clk, arst_n, !busy_q && !q_empty, busy_q)
endmodule
`default_nettype wire

FILE: src/prefix_compressed_block_encoder.sv
// Top level of the prefix-compressed block encoder.
// Usage: the block takes one input item per cycle unless a full queue or Finish stalls it. An
// item that yields results becomes one command for a four-entry queue, and the output side
// drains it one result per cycle while the receiver is ready, through a registered output
// stage, so an entry header (up to ten block bytes) runs behind the input while later key and
// value bytes keep arriving; the queue depth sets how long a header burst can be absorbed
// before the input stalls. Finish reads the restart offsets out of their store one per cycle
// as queue space allows. There is no clearing pass after reset. The user must write the
// restart interval over the APB port at address 0 only while the block is idle; not enforced.
`default_nettype none
module prefix_compressed_block_encoder #(
	parameter int MAX_KEY_BYTES = 256,
	parameter int MAX_RESTARTS  = 63
) (
	input  logic                          clk,
	input  logic                          arst_n,
	pcbe_stream_if.sink                   item,
	pcbe_stream_if.source                 result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pcbe_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import pcbe_pkg::*;

	logic [INTERVAL_W-1:0] interval_q;
	logic                  reg_hit, q_push, q_pop, q_full, q_empty;
	cmd_t                  q_wdata, q_rdata;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_RESTART_INTERVAL);
	assign prdata  = reg_hit ? 32'(interval_q) : '0;

	// Restart interval register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			interval_q <= pwdata[INTERVAL_W-1:0];
		end
	end

	pcbe_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES), .MAX_RESTARTS(MAX_RESTARTS)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.item             (item),
		.restart_interval (interval_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_data           (q_wdata)
	);

	pcbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	pcbe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);
endmodule
`default_nettype wire

FILE: dv/pcbe_block_checker.sv
// Checker for the prefix-compressed block encoder: predicts results from observed transfers.
`default_nettype none
module pcbe_block_checker
	import pcbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  in_item_t    item_payload,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result_payload,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          pending
);

	localparam int KEY_MAX = 256;
	localparam int RST_MAX = 63;

	// Predicted encoder state.
	logic [7:0]  prior_key [KEY_MAX];
	logic [31:0] prior_len, key_len, val_left, kpos;
	logic        matching, hdr_done, ovf;
	logic [31:0] since_restart, blk_offset;
	logic [31:0] restart_tab [RST_MAX];
	int          restart_n;
	logic [INTERVAL_W-1:0] interval;

	result_t batch[$];
	result_t expected_results[$];

	task automatic put_result(input logic [1:0] kind, input logic [31:0] val);
		result_t r;
		r.kind = kind;
		r.out_value = val;
		r.overflow = ovf;
		r.last = 1'b0;
		batch.insert(batch.size(), r);
		if (kind == KIND_BYTE) blk_offset = blk_offset + 1;
	endtask

	task automatic put_leb128(input logic [31:0] v);
		while (v >= 32'h80) begin
			put_result(KIND_BYTE, (v & 32'h7F) | 32'h80);
			v = v >> 7;
		end
		put_result(KIND_BYTE, v);
	endtask

	task automatic put_header(input logic [31:0] shared);
		put_leb128(shared);
		put_leb128(key_len - shared);
		put_leb128(val_left);
		hdr_done = 1'b1;
		matching = 1'b0;
	endtask

	task automatic clear_block();
		for (int i = 0; i < KEY_MAX; i++) prior_key[i] = 8'd0;
		for (int i = 0; i < RST_MAX; i++) restart_tab[i] = 32'd0;
		prior_len = 0;
		key_len = 0;
		val_left = 0;
		kpos = 0;
		matching = 1'b0;
		hdr_done = 1'b0;
		since_restart = 0;
		blk_offset = 0;
		restart_n = 1;
		ovf = 1'b0;
	endtask

	// Work out the results that one accepted item causes.
	task automatic encode_item(input in_item_t it);
		logic [31:0] run;
		logic        restart, hit;
		run = (interval == 0) ? 32'd1 : 32'(interval);
		batch.delete();
		case (it.op)
			OP_BEGIN: begin
				restart = (since_restart >= run);
				if (restart) begin
					if (restart_n < RST_MAX) begin
						restart_tab[restart_n] = blk_offset;
						restart_n++;
					end else begin
						ovf = 1'b1;
					end
					since_restart = 0;
				end
				since_restart = since_restart + 1;
				prior_len = kpos;
				kpos = 0;
				key_len = (it.key_length > KEY_MAX) ? KEY_MAX : 32'(it.key_length);
				val_left = it.val_len;
				matching = !restart;
				hdr_done = 1'b0;
				if (key_len == 0) put_header(0);
			end
			OP_KEY: begin
				if (kpos < key_len) begin
					hit = matching && kpos < prior_len && prior_key[kpos] == it.data_byte;
					if (!hdr_done && !hit) put_header(kpos);
					if (hdr_done) put_result(KIND_BYTE, 32'(it.data_byte));
					prior_key[kpos] = it.data_byte;
					kpos = kpos + 1;
					if (kpos == key_len && !hdr_done) put_header(key_len);
				end
			end
			OP_VALUE: begin
				if (hdr_done && kpos == key_len && val_left > 0) begin
					put_result(KIND_BYTE, 32'(it.data_byte));
					val_left = val_left - 1;
				end
			end
			default: begin
				for (int i = 0; i < restart_n; i++) put_result(KIND_OFFSET, restart_tab[i]);
				put_result(KIND_COUNT, 32'(restart_n));
				clear_block();
			end
		endcase
		if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
		foreach (batch[i]) expected_results.insert(expected_results.size(), batch[i]);
	endtask

	// Track register writes, predict on input transfers, compare on output transfers.
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			clear_block();
			interval = INTERVAL_RESET;
			expected_results.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_RESTART_INTERVAL, 2'b00})
				interval = pwdata[INTERVAL_W-1:0];
			if (item_valid && item_ready) encode_item(item_payload);
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with none expected: kind %0d value %h ovf %b last %b",
							result_payload.kind, result_payload.out_value,
							result_payload.overflow, result_payload.last);
				end else begin
					e = expected_results.pop_front();
					if (e.kind != result_payload.kind ||
						e.out_value != result_payload.out_value ||
						e.overflow != result_payload.overflow ||
						e.last != result_payload.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected kind %0d value %h ovf %b last %b, ",
								"got kind %0d value %h ovf %b last %b"},
								e.kind, e.out_value, e.overflow, e.last,
								result_payload.kind, result_payload.out_value,
								result_payload.overflow, result_payload.last);
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule
`default_nettype wire

FILE: dv/tb_prefix_compressed_block_encoder.sv
// Testbench top of the prefix-compressed block encoder: stimulus, clocking and verdict.
`default_nettype none
module tb_prefix_compressed_block_encoder;
	import pcbe_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD  = 300;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	int   mismatches, pending;
	int   idle_cycles, item_count;
	logic calm, hold_req;
	logic [7:0]  key_buf [512];
	int          key_n;

	pcbe_stream_if #(.payload_t(in_item_t)) item_ch ();
	pcbe_stream_if #(.payload_t(result_t))  result_ch ();

	prefix_compressed_block_encoder dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pcbe_block_checker chk (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_ch.valid), .item_ready(item_ch.ready), .item_payload(item_ch.payload),
		.result_valid(result_ch.valid), .result_ready(result_ch.ready),
		.result_payload(result_ch.payload),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
	);

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL prefix_compressed_block_encoder");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Receiver: random stall bursts, one long hold on request, none in the calm part.
	initial begin
		int n;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				result_ch.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 9);
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one item, with an occasional gap before it, and wait for its transfer.
	task automatic put_item(input logic [1:0] op, input logic [7:0] b,
			input logic [8:0] klen, input logic [31:0] vlen);
		in_item_t it;
		logic ok;
		it.op = op;
		it.data_byte = b;
		it.key_length = klen;
		it.val_len = vlen;
		if (!calm && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do begin
			@(negedge clk);
			ok = item_ch.ready;
			@(posedge clk);
		end while (!ok);
		item_count++;
	endtask

	// Drop valid, wait for every expected result, then let the pipeline drain.
	task automatic settle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	// APB write of the restart interval: setup then access cycle.
	task automatic write_interval(input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_RESTART_INTERVAL, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One random entry sharing a random prefix with the last one, with rare malformations.
	task automatic random_entry();
		int shared, klen, sent, flaw;
		logic [31:0] vlen;
		logic [8:0]  klen_field;
		shared = $urandom_range(0, key_n);
		klen = shared + $urandom_range(0, 6);
		if (klen > 256) klen = 256;
		for (int i = shared; i < klen; i++)
			key_buf[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h61 + 8'($urandom_range(0, 1));
		klen_field = 9'(klen);
		if ($urandom_range(0, 40) == 0) klen_field = 9'($urandom_range(257, 511));
		case ($urandom_range(0, 15))
			0: vlen = $urandom;
			1: vlen = $urandom_range(128, 300);
			default: vlen = $urandom_range(0, 5);
		endcase
		flaw = $urandom_range(0, 15);
		put_item(OP_BEGIN, 8'($urandom), klen_field, vlen);
		if (flaw == 2) put_item(OP_VALUE, 8'($urandom), 9'($urandom), $urandom);
		sent = (flaw == 0 && klen > 0) ? $urandom_range(0, klen - 1) : klen;
		for (int i = 0; i < sent; i++) put_item(OP_KEY, key_buf[i], 9'($urandom), $urandom);
		if (flaw == 1) put_item(OP_KEY, 8'($urandom), 9'($urandom), $urandom);
		if (klen_field == klen && flaw != 0) begin
			for (int i = 0; i < (vlen > 6 ? 3 : vlen); i++)
				put_item(OP_VALUE, 8'($urandom), 9'($urandom), $urandom);
			if (flaw == 3) put_item(OP_VALUE, 8'($urandom), 9'($urandom), $urandom);
		end
		key_n = sent;
	endtask

	// Stimulus and verdict.
	initial begin
		logic [31:0] run_len [6];
		run_len = '{32'd3, 32'd1, 32'd1024, 32'd0, 32'd2, 32'd7};
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		key_n = 0;
		item_count = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty key, extreme lengths, full prefix, key that is a prefix, strays.
		put_item(OP_BEGIN, 8'h00, 9'd0, 32'd0);
		put_item(OP_BEGIN, 8'hFF, 9'd3, 32'hFFFF_FFFF);
		put_item(OP_VALUE, 8'hAA, 9'd0, 32'd0);
		put_item(OP_KEY, 8'h00, 9'h1FF, 32'hFFFF_FFFF);
		put_item(OP_KEY, 8'hFF, 9'd0, 32'd0);
		put_item(OP_KEY, 8'h80, 9'd0, 32'd0);
		put_item(OP_VALUE, 8'hFF, 9'd0, 32'd0);
		put_item(OP_BEGIN, 8'h00, 9'd3, 32'd1);
		put_item(OP_KEY, 8'h00, 9'd0, 32'd0);
		put_item(OP_KEY, 8'hFF, 9'd0, 32'd0);
		put_item(OP_KEY, 8'h80, 9'd0, 32'd0);
		put_item(OP_KEY, 8'h11, 9'd0, 32'd0);
		put_item(OP_VALUE, 8'h00, 9'd0, 32'd0);
		put_item(OP_VALUE, 8'h55, 9'd0, 32'd0);
		put_item(OP_BEGIN, 8'h00, 9'd2, 32'd200);
		put_item(OP_KEY, 8'h00, 9'd0, 32'd0);
		put_item(OP_KEY, 8'hFF, 9'd0, 32'd0);
		put_item(OP_BEGIN, 8'h00, 9'h1FF, 32'd0);
		put_item(OP_KEY, 8'h01, 9'd0, 32'd0);
		put_item(OP_KEY, 8'h7F, 9'd0, 32'd0);
		put_item(OP_FINISH, 8'h00, 9'd0, 32'd0);
		put_item(OP_FINISH, 8'h00, 9'd0, 32'd0);
		key_n = 0;
		settle();

		// Random phases, each under its own restart interval.
		for (int ph = 0; ph < 6; ph++) begin
			write_interval(run_len[ph]);
			if (ph == 2) hold_req = 1'b1;
			if (ph == 5) calm = 1'b1;
			if (ph == 1) begin
				// Enough restarts to overflow the offset store.
				for (int i = 0; i < 66; i++) put_item(OP_BEGIN, 8'($urandom), 9'd0, 32'($urandom_range(0, 3)));
				put_item(OP_FINISH, 8'($urandom), 9'($urandom), $urandom);
				key_n = 0;
			end
			while (item_count < 60 + 55 * (ph + 1)) begin
				random_entry();
				if ($urandom_range(0, 19) == 0) begin
					put_item(OP_FINISH, 8'($urandom), 9'($urandom), $urandom);
					key_n = 0;
				end
			end
			if (ph % 2 == 1) begin
				put_item(OP_FINISH, 8'($urandom), 9'($urandom), $urandom);
				key_n = 0;
			end
			settle();
		end

		if (mismatches == 0 && pending == 0) begin
			$display("PASS prefix_compressed_block_encoder");
		end else begin
			$display("FAIL prefix_compressed_block_encoder");
		end
		$finish;
	end

endmodule
`default_nettype wire
